### hdl/ptob_pkg.sv
package ptob_pkg;

  localparam int BOOK_DEPTH  = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(MAX_RESULTS);

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_MATCH  = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_FILL    = 3'd2;
  localparam logic [2:0] ST_NOFILL  = 3'd3;
  localparam logic [2:0] ST_CXL_OK  = 3'd4;
  localparam logic [2:0] ST_CXL_REJ = 3'd5;

  typedef struct packed {
    logic load;
    logic scan;
    logic add;
    logic fill;
    logic finish_match;
    logic finish_cancel;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic left_zero;
    logic fill_final;
    logic is_match;
  } stat_t;

endpackage

### hdl/ptob_ctrl.sv
module ptob_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         action,
  input  ptob_pkg::stat_t    st,
  output ptob_pkg::cmd_t     cmd,
  output logic               busy
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ADD    = 6'b000010,
    S_SCAN   = 6'b000100,
    S_TAIL   = 6'b001000,
    S_DECIDE = 6'b010000,
    S_FILL   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (action)
            ptob_pkg::ACT_ADD:    state_next = S_ADD;
            ptob_pkg::ACT_MATCH:  state_next = S_SCAN;
            ptob_pkg::ACT_CANCEL: state_next = S_SCAN;
            default:              state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.is_match) begin
          if (st.found && !st.left_zero) begin
            state_next = S_FILL;
          end else begin
            cmd.finish_match = 1'b1;
            state_next       = S_IDLE;
          end
        end else begin
          cmd.finish_cancel = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        // after the final fill skip the scan and release the held fill as last
        state_next = st.fill_final ? S_DECIDE : S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/ptob_dp.sv
module ptob_dp (
  input  logic               clk,
  input  logic               rst,
  input  ptob_pkg::cmd_t     cmd,
  output ptob_pkg::stat_t    st,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic [1:0]         action,
  input  logic [31:0]        order_ref,
  input  logic [31:0]        limit_price,
  input  logic [31:0]        quantity,
  input  logic [31:0]        arrival_time,
  output logic               strobe,
  output logic [2:0]         status,
  output logic [31:0]        resting_id,
  output logic [31:0]        fill_quantity,
  output logic [31:0]        execution_number,
  output logic [31:0]        incoming_left,
  output logic               last_result
);

  localparam int D  = ptob_pkg::BOOK_DEPTH;
  localparam int IW = ptob_pkg::IW;
  localparam int CW = ptob_pkg::CW;

  logic book_side;

  logic [31:0] m_id    [D];
  logic [31:0] m_price [D];
  logic [31:0] m_qty   [D];
  logic [31:0] m_time  [D];
  logic [31:0] m_exec  [D];
  logic [D-1:0] valid;

  logic [1:0]  act;
  logic [31:0] cid, cprice, left, cts;

  logic [IW-1:0] idx;
  logic [31:0] rd_id, rd_price, rd_qty, rd_time, rd_exec;
  logic [IW-1:0] rd_slot;
  logic        rd_valid, rd_live;

  logic          found;
  logic [IW-1:0] bslot;
  logic [31:0]   bid, bprice, bqty, btime, bexec;

  logic [CW-1:0] count;
  logic          pend_v;
  logic [31:0]   p_id, p_fill, p_exec, p_left;

  logic          full;
  logic [IW-1:0] free_slot;
  logic          cand, ahead;
  logic [31:0]   fill_q, new_left, new_q, new_exec;
  logic          fill_final;
  logic          add_wr;
  logic [IW-1:0] wa;

  always_comb begin
    free_slot = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = IW'(i);
      end
    end
  end
  assign full = &valid;

  always_comb begin
    if (rd_price != bprice) begin
      ahead = book_side ? (rd_price < bprice) : (rd_price > bprice);
    end else begin
      ahead = rd_time < btime;
    end
    if (act == ptob_pkg::ACT_MATCH) begin
      cand = rd_live && rd_valid &&
             (book_side ? (rd_price <= cprice) : (rd_price >= cprice));
    end else begin
      cand = rd_live && rd_valid && (rd_id == cid);
    end
  end

  assign fill_q     = (left < bqty) ? left : bqty;
  assign new_left   = left - fill_q;
  assign new_q      = bqty - fill_q;
  assign new_exec   = bexec + 32'd1;
  assign fill_final = (new_left == 32'd0) || (count == CW'(ptob_pkg::MAX_RESULTS - 1));
  assign add_wr     = cmd.add && (left != 32'd0) && !full;
  assign wa         = cmd.add ? free_slot : bslot;

  assign st.scan_last  = (idx == IW'(D - 1));
  assign st.found      = found;
  assign st.left_zero  = (left == 32'd0);
  assign st.fill_final = fill_final;
  assign st.is_match   = (act == ptob_pkg::ACT_MATCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      book_side <= 1'b0;
    end else if (cfg_write) begin
      book_side <= cfg_data;
    end
  end

  // entry memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (add_wr) begin
      m_id[wa]    <= cid;
      m_price[wa] <= cprice;
      m_time[wa]  <= cts;
    end
    if (add_wr || cmd.fill) begin
      m_qty[wa]  <= cmd.add ? left : new_q;
      m_exec[wa] <= cmd.add ? 32'd0 : new_exec;
    end
    rd_id    <= m_id[idx];
    rd_price <= m_price[idx];
    rd_qty   <= m_qty[idx];
    rd_time  <= m_time[idx];
    rd_exec  <= m_exec[idx];
    rd_slot  <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      rd_live <= 1'b0;
      rd_valid <= 1'b0;
      found   <= 1'b0;
      idx     <= '0;
      count   <= '0;
      pend_v  <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe   <= 1'b0;
      rd_live  <= cmd.scan;
      rd_valid <= valid[idx];
      if (cmd.scan) begin
        idx <= idx + IW'(1);
      end
      if (cand && (!found || ahead)) begin
        found <= 1'b1;
      end
      if (cmd.load) begin
        idx    <= '0;
        found  <= 1'b0;
        count  <= '0;
        pend_v <= 1'b0;
      end
      if (add_wr) begin
        valid[free_slot] <= 1'b1;
      end
      if (cmd.add) begin
        strobe <= 1'b1;
      end
      if (cmd.fill) begin
        idx   <= '0;
        found <= 1'b0;
        count <= count + CW'(1);
        if (new_q == 32'd0) begin
          valid[bslot] <= 1'b0;
        end
        strobe <= pend_v;
        pend_v <= 1'b1;
      end
      if (cmd.finish_match || cmd.finish_cancel) begin
        strobe <= 1'b1;
        pend_v <= 1'b0;
      end
      if (cmd.finish_cancel && found && (btime < cts)) begin
        valid[bslot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= action;
      cid    <= order_ref;
      cprice <= limit_price;
      left   <= quantity;
      cts    <= arrival_time;
    end
    if (cand && (!found || ahead)) begin
      bslot  <= rd_slot;
      bid    <= rd_id;
      bprice <= rd_price;
      bqty   <= rd_qty;
      btime  <= rd_time;
      bexec  <= rd_exec;
    end
    if (cmd.add) begin
      status           <= (left != 32'd0 && full) ? ptob_pkg::ST_FULL : ptob_pkg::ST_ADDED;
      resting_id       <= cid;
      fill_quantity    <= '0;
      execution_number <= '0;
      incoming_left    <= '0;
      last_result      <= 1'b1;
    end
    if (cmd.fill) begin
      left <= new_left;
      // release the held fill; this one waits to learn if it is the last
      status           <= ptob_pkg::ST_FILL;
      resting_id       <= p_id;
      fill_quantity    <= p_fill;
      execution_number <= p_exec;
      incoming_left    <= p_left;
      last_result      <= 1'b0;
      p_id   <= bid;
      p_fill <= fill_q;
      p_exec <= new_exec;
      p_left <= new_left;
    end
    if (cmd.finish_match) begin
      last_result <= 1'b1;
      if (pend_v) begin
        status           <= ptob_pkg::ST_FILL;
        resting_id       <= p_id;
        fill_quantity    <= p_fill;
        execution_number <= p_exec;
        incoming_left    <= p_left;
      end else begin
        status           <= ptob_pkg::ST_NOFILL;
        resting_id       <= '0;
        fill_quantity    <= '0;
        execution_number <= '0;
        incoming_left    <= left;
      end
    end
    if (cmd.finish_cancel) begin
      status           <= (found && (btime < cts)) ? ptob_pkg::ST_CXL_OK
                                                   : ptob_pkg::ST_CXL_REJ;
      resting_id       <= cid;
      fill_quantity    <= '0;
      execution_number <= '0;
      incoming_left    <= '0;
      last_result      <= 1'b1;
    end
  end

endmodule

### hdl/price_time_order_book_unit.sv
// Add: the transfer moves to the add state (busy), which registers the result strobe.
// Cancel: one book scan (one entry read per cycle, BOOK_DEPTH entries), then the tail
// and decide states, which register the result. Match: scan, tail and decide, and each
// fill adds a fill state and a rescan; the final fill skips the rescan (at most 32 fills).
// Results are one-cycle strobes the receiver cannot stall; busy is high while working.
// Synchronous active-high rst empties the book and sets book_side to buy.
module price_time_order_book_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic [1:0]  action,
  input  logic [31:0] order_ref,
  input  logic [31:0] limit_price,
  input  logic [31:0] quantity,
  input  logic [31:0] arrival_time,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [31:0] resting_id,
  output logic [31:0] fill_quantity,
  output logic [31:0] execution_number,
  output logic [31:0] incoming_left,
  output logic        last_result
);

  ptob_pkg::cmd_t  cmd;
  ptob_pkg::stat_t st;

  ptob_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .st(st), .cmd(cmd), .busy(busy)
  );

  ptob_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .action(action), .order_ref(order_ref), .limit_price(limit_price),
    .quantity(quantity), .arrival_time(arrival_time),
    .strobe(strobe), .status(status), .resting_id(resting_id),
    .fill_quantity(fill_quantity), .execution_number(execution_number),
    .incoming_left(incoming_left), .last_result(last_result)
  );

endmodule

### hdl/ptob_checker.sv
module ptob_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  action,
  input logic        strobe,
  input logic [2:0]  status,
  input logic        last_result
);

  // a real command must raise busy after its transfer
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (action != ptob_pkg::ACT_NONE) |=> busy)
    else $error("busy not raised after transfer");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != ptob_pkg::ST_FILL) |-> last_result)
    else $error("single result not marked last");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe && !busy)
    else $error("activity right after reset");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last_result |-> !busy)
    else $error("busy after last result");

endmodule

bind price_time_order_book_unit ptob_checker u_ptob_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
  .strobe(strobe), .status(status), .last_result(last_result)
);
